@@ hw/rtl/tkd_pkg.sv @@
// Shared constants and types for the top-k dominating core.
`default_nettype none
package tkd_pkg;
  localparam int N_MAX = 1024;
  localparam int D_MAX = 8;
  localparam int K_MAX = 16;
  localparam int DEPTH = N_MAX * D_MAX;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(N_MAX);
  localparam int DW = $clog2(D_MAX);
  localparam int KW = $clog2(K_MAX);
  localparam int CW = AW + 1;
  localparam int SW = PW + 1;

  // reciprocals for the point count: (x * RCP_n) >> RCP_SHIFT == x / n
  // exact for every x below 2**(CW+1), since x * (RCP_n * n - 2**RCP_SHIFT) stays
  // below 2**RCP_SHIFT
  localparam int RCP_SHIFT = 18;
  localparam int RCP_W = RCP_SHIFT + 1;
  localparam logic [RCP_W-1:0] RCP_1 = RCP_W'(262144);
  localparam logic [RCP_W-1:0] RCP_2 = RCP_W'(131072);
  localparam logic [RCP_W-1:0] RCP_3 = RCP_W'(87382);
  localparam logic [RCP_W-1:0] RCP_4 = RCP_W'(65536);
  localparam logic [RCP_W-1:0] RCP_5 = RCP_W'(52429);
  localparam logic [RCP_W-1:0] RCP_6 = RCP_W'(43691);
  localparam logic [RCP_W-1:0] RCP_7 = RCP_W'(37450);
  localparam logic [RCP_W-1:0] RCP_8 = RCP_W'(32768);

  localparam logic [1:0] CFG_DIM = 2'd0;
  localparam logic [1:0] CFG_DIR = 2'd1;
  localparam logic [1:0] CFG_TOP = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_run;
    logic init_i;
    logic init_j;
    logic init_d;
    logic rd_issue;
    logic latch_p;
    logic cmp;
    logic next_d;
    logic end_pair;
    logic next_i;
    logic rank_start;
    logic rank_step;
    logic init_out;
    logic next_out;
  } tkd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_points;
    logic last_d;
    logic last_j;
    logic last_i;
    logic rank_done;
    logic last_out;
  } tkd_stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/tkd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module tkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read through an output register
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/tkd_datapath.sv @@
// Datapath: element store, pairwise comparison, score counting and ranked list.
`default_nettype none
module tkd_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tkd_pkg::tkd_cmd_t   cmd,
  output tkd_pkg::tkd_stat_t       stat,
  input  wire logic [31:0]         in_value,
  input  wire logic                in_missing,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_idx,
  input  wire logic [7:0]          cfg_data,
  output logic [9:0]               res_index,
  output logic [9:0]               res_score,
  output logic                     res_overflow
);
  import tkd_pkg::*;

  logic [3:0] dim_count;
  logic [7:0] direction_mask;
  logic [4:0] top_count;
  logic [CW-1:0] element_count;
  logic dropped_flag;
  logic [DW:0] dim;
  logic [KW:0] k_eff;
  logic [CW-1:0] cap;
  logic [SW-1:0] points;
  logic [PW-1:0] pi, pj;
  logic [DW-1:0] d;
  logic [AW-1:0] addr_p, addr_q;
  logic          phase;          // 0: read p element, 1: read q element
  logic [32:0]   rd_p, rd_q;
  logic [32:0]   ram_rdata;
  logic [AW-1:0] raddr;
  logic          better, worse;
  logic [SW-1:0] sc;
  logic [PW-1:0] best_index [K_MAX];
  logic [SW-1:0] best_score [K_MAX];
  logic [KW:0]   best_fill;
  logic [KW:0]   pos;
  logic [KW:0]   out_pos;
  logic          rank_busy;
  logic [CW+DW:0] pts_num;
  logic [RCP_W-1:0] rcp;
  logic [CW+DW+RCP_W:0] pts_mul;
  logic [CW+DW:0] pts_full;

  // effective configuration
  always_comb begin
    if (dim_count == 4'd0) dim = (DW+1)'(1);
    else if (32'(dim_count) > D_MAX) dim = (DW+1)'(D_MAX);
    else dim = (DW+1)'(dim_count);
    if (top_count == 5'd0) k_eff = (KW+1)'(1);
    else if (32'(top_count) > K_MAX) k_eff = (KW+1)'(K_MAX);
    else k_eff = (KW+1)'(top_count);
    cap = CW'(N_MAX) * CW'(dim);
  end

  // point count: ceil(element_count / dim), by reciprocal multiplication
  always_comb begin
    pts_num = (CW+DW+1)'(element_count) + (CW+DW+1)'(dim) - (CW+DW+1)'(1);
    case (dim)
      (DW+1)'(1): rcp = RCP_1;
      (DW+1)'(2): rcp = RCP_2;
      (DW+1)'(3): rcp = RCP_3;
      (DW+1)'(4): rcp = RCP_4;
      (DW+1)'(5): rcp = RCP_5;
      (DW+1)'(6): rcp = RCP_6;
      (DW+1)'(7): rcp = RCP_7;
      default:    rcp = RCP_8;
    endcase
    pts_mul  = (CW+DW+1+RCP_W)'(pts_num) * (CW+DW+1+RCP_W)'(rcp);
    pts_full = (CW+DW+1)'(pts_mul >> RCP_SHIFT);
    // cap before narrowing
    if (pts_full > (CW+DW+1)'(N_MAX)) points = SW'(N_MAX);
    else points = SW'(pts_full);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= 4'd1; direction_mask <= 8'd0; top_count <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DIM: dim_count <= cfg_data[3:0];
        CFG_DIR: direction_mask <= cfg_data;
        CFG_TOP: top_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic ram_we;
  assign ram_we = cmd.load && (element_count < cap);
  assign raddr = phase ? addr_q : addr_p;

  tkd_ram #(.WIDTH(33), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(element_count[AW-1:0]),
    .wdata({in_missing, in_value ^ 32'h8000_0000}),
    .raddr(raddr), .rdata(ram_rdata)
  );

  // present checks use element_count bound; addresses of partial tail are skipped
  logic p_ok, q_ok, bigger;
  assign p_ok = (CW'(addr_p) < element_count) && !rd_p[32];
  assign q_ok = (CW'(addr_q) < element_count) && !ram_rdata[32];
  assign bigger = direction_mask[d[DW-1:0] & 3'h7];

  logic [KW:0] ins_pos;
  logic        do_ins;
  assign do_ins = !((best_fill >= k_eff) &&
                    (sc <= best_score[KW'(k_eff - (KW+1)'(1))]));

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0; dropped_flag <= 1'b0; best_fill <= '0;
      rank_busy <= 1'b0; phase <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (element_count < cap) element_count <= element_count + CW'(1);
        else dropped_flag <= 1'b1;
      end
      if (cmd.clr_run) begin
        element_count <= '0; dropped_flag <= 1'b0; best_fill <= '0;
      end
      if (cmd.init_i) begin
        pi <= '0; best_fill <= '0; addr_p <= '0;
      end
      if (cmd.init_j) begin
        pj <= '0; sc <= '0;
      end
      if (cmd.init_d) begin
        d <= '0; better <= 1'b0; worse <= 1'b0;
        addr_p <= AW'(pi) * AW'(dim);
        addr_q <= AW'(pj) * AW'(dim);
      end
      // two reads per element: p then q
      if (cmd.rd_issue) phase <= 1'b1;
      if (cmd.cmp) begin
        phase <= 1'b0;
        if (p_ok && q_ok && (rd_p[31:0] != ram_rdata[31:0])) begin
          if ((rd_p[31:0] > ram_rdata[31:0]) == bigger) better <= 1'b1;
          else worse <= 1'b1;
        end
      end
      if (cmd.next_d) begin
        d <= d + DW'(1); addr_p <= addr_p + AW'(1); addr_q <= addr_q + AW'(1);
      end
      if (cmd.end_pair) begin
        if (pj != pi && better && !worse) sc <= sc + SW'(1);
        pj <= pj + PW'(1);
      end
      if (cmd.rank_start) begin
        rank_busy <= do_ins;
        ins_pos   <= (best_fill < k_eff) ? best_fill : k_eff - (KW+1)'(1);
        if (do_ins && best_fill < k_eff) best_fill <= best_fill + (KW+1)'(1);
      end
      // shift one entry down per cycle, then place
      if (cmd.rank_step && rank_busy) begin
        if (ins_pos != '0 && best_score[KW'(ins_pos - (KW+1)'(1))] < sc) begin
          best_score[KW'(ins_pos)] <= best_score[KW'(ins_pos - (KW+1)'(1))];
          best_index[KW'(ins_pos)] <= best_index[KW'(ins_pos - (KW+1)'(1))];
          ins_pos <= ins_pos - (KW+1)'(1);
        end else begin
          best_score[KW'(ins_pos)] <= sc;
          best_index[KW'(ins_pos)] <= pi;
          rank_busy <= 1'b0;
        end
      end
      if (cmd.next_i) pi <= pi + PW'(1);
      if (cmd.init_out) out_pos <= '0;
      if (cmd.next_out) out_pos <= out_pos + (KW+1)'(1);
    end
  end

  // latch p element when its read returns
  always_ff @(posedge clk) begin
    if (cmd.latch_p) rd_p <= ram_rdata;
  end
  assign rd_q = ram_rdata;
  assign pos = ins_pos;

  assign stat.no_points = (points == '0);
  assign stat.last_d    = (32'(d) + 1 >= 32'(dim));
  assign stat.last_j    = (SW'(pj) + SW'(1) >= points);
  assign stat.last_i    = (SW'(pi) + SW'(1) >= points);
  assign stat.rank_done = !rank_busy;
  assign stat.last_out  = (out_pos + (KW+1)'(1) >= best_fill);

  assign res_index    = stat.no_points ? 10'd0 : 10'(best_index[KW'(out_pos)]);
  assign res_score    = stat.no_points ? 10'd0 : 10'(best_score[KW'(out_pos)]);
  assign res_overflow = dropped_flag;
  logic unused;
  assign unused = ^{rd_q, pos};
endmodule
`default_nettype wire

@@ hw/rtl/tkd_ctrl.sv @@
// Controller: load, pairwise compare loop, ranking and result delivery.
`default_nettype none
module tkd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic               in_eos,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_last,
  output logic                    out_empty,
  output tkd_pkg::tkd_cmd_t       cmd,
  input  wire tkd_pkg::tkd_stat_t stat
);
  import tkd_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_PAIR, S_RDP, S_RDQ, S_CMP, S_PEND, S_RANK, S_RWAIT, S_OUT, S_EMPTY
  } state_t;
  state_t state;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT) || (state == S_EMPTY);
  assign out_empty = (state == S_EMPTY);
  assign out_last  = (state == S_EMPTY) || stat.last_out;

  // datapath commands issued from clocked transitions
  logic go_i, go_j, go_nexti, go_init_out, go_next_out, go_clr;
  always_comb begin
    go_i = (state == S_LOAD) && in_fire && in_eos && !stat.no_points;
    go_j = go_i || (state == S_RWAIT && stat.rank_done && !stat.last_i);
    go_nexti = (state == S_RWAIT && stat.rank_done && !stat.last_i);
    go_init_out = (state == S_RWAIT && stat.rank_done && stat.last_i);
    go_next_out = (state == S_OUT && out_ready);
    go_clr = out_valid && out_ready && out_last;
  end

  always_comb begin
    cmd = '0;
    cmd.load = in_fire && !in_eos && state == S_LOAD;
    case (state)
      S_PAIR:  cmd.init_d = 1'b1;
      S_RDP:   cmd.rd_issue = 1'b1;
      S_RDQ:   cmd.latch_p = 1'b1;
      S_CMP:   begin cmd.cmp = 1'b1; cmd.next_d = !stat.last_d; end
      S_PEND:  cmd.end_pair = 1'b1;
      S_RANK:  cmd.rank_start = 1'b1;
      S_RWAIT: cmd.rank_step = 1'b1;
      default: ;
    endcase
    cmd.init_i   = go_i;
    cmd.init_j   = go_j;
    cmd.next_i   = go_nexti;
    cmd.init_out = go_init_out;
    cmd.next_out = go_next_out;
    cmd.clr_run  = go_clr;
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      case (state)
        S_LOAD:  if (in_fire && in_eos) state <= stat.no_points ? S_EMPTY : S_PAIR;
        S_PAIR:  state <= S_RDP;
        S_RDP:   state <= S_RDQ;
        S_RDQ:   state <= S_CMP;
        S_CMP:   state <= stat.last_d ? S_PEND : S_RDP;
        S_PEND:  state <= stat.last_j ? S_RANK : S_PAIR;
        S_RANK:  state <= S_RWAIT;
        S_RWAIT: if (stat.rank_done) state <= stat.last_i ? S_OUT : S_PAIR;
        S_OUT:   if (out_ready && stat.last_out) state <= S_LOAD;
        S_EMPTY: if (out_ready) state <= S_LOAD;
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/top_k_dominating_incomplete_core.sv @@
// Top level of the top-k dominating query core over points with missing values.
//
// Elements stream in at one transfer per cycle and are written to an 8192-entry
// store. An end_of_set transfer starts the compute phase: every ordered pair of
// points is compared dimension by dimension, its two elements read one after the
// other through the single read port of the element store, and each point is
// ranked after its pairs. Results then leave at one per cycle while tready is
// high. Input is not taken during compute and delivery.
`default_nettype none
module top_k_dominating_incomplete_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], missing[32], zeros
  input  wire logic        s_tuser,   // end_of_set
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // point_index[9:0], score[19:10], overflow[20], zeros
  output logic             m_tlast,   // last
  output logic             m_tuser,   // empty_res
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import tkd_pkg::*;

  tkd_cmd_t  cmd;
  tkd_stat_t stat;
  logic [9:0] ri, rs;
  logic ov, in_fire;

  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  tkd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_eos(s_tuser), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
    .out_empty(m_tuser), .cmd(cmd), .stat(stat)
  );

  tkd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_value(s_tdata[31:0]), .in_missing(s_tdata[32]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .res_index(ri), .res_score(rs), .res_overflow(ov)
  );

  assign m_tdata = {3'd0, ov, rs, ri};
  logic unused;
  assign unused = ^{s_tdata[39:33]};
endmodule
`default_nettype wire

@@ verif/tb_top_k_dominating_incomplete_core.sv @@
// Self-checking testbench for the top-k dominating core over incomplete points.
`timescale 1ns / 100ps
module tb_top_k_dominating_incomplete_core;
  import tkd_pkg::*;

  typedef struct {
    int unsigned pidx;
    int unsigned pscore;
    bit          plast;
    bit          pempty;
    bit          povf;
  } ranked_pt_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // value[31:0], missing[32], zeros
  logic        s_tuser = 1'b0; // end_of_set
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // point_index[9:0], score[19:10], overflow[20], zeros
  logic        m_tlast;        // last
  logic        m_tuser;        // empty_res
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_DIM;
  logic [7:0]  cfg_data = '0;

  top_k_dominating_incomplete_core dut (.*);

  always #4 clk = ~clk;

  // Predictor state: configuration copy and loaded elements
  int unsigned       dims_reg = 1;
  int unsigned       dir_reg = 0;
  int unsigned       topk_reg = 1;
  logic signed [31:0] elem_val [DEPTH];
  bit                elem_miss [DEPTH];
  int unsigned       elem_cnt = 0;
  bit                dropped = 1'b0;
  ranked_pt_t        pending_ranks [$];
  int unsigned       mismatches = 0;
  int unsigned       items_sent = 0;
  bit                calm = 1'b0;

  function automatic int unsigned eff_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > D_MAX) return D_MAX;
    return dims_reg;
  endfunction

  function automatic bit has_elem(int unsigned a);
    return a < elem_cnt && !elem_miss[a];
  endfunction

  // True when point p beats q in some shared dimension and loses in none
  function automatic bit beats(int unsigned p, int unsigned q, int unsigned nd);
    int unsigned up = 0, down = 0;
    bit          pref_big;
    for (int unsigned d = 0; d < nd; d++) begin
      if (!has_elem(p * nd + d) || !has_elem(q * nd + d)) continue;
      if (elem_val[p * nd + d] == elem_val[q * nd + d]) continue;
      pref_big = dir_reg[d % 8];
      if ((elem_val[p * nd + d] > elem_val[q * nd + d]) == pref_big) up++;
      else down++;
    end
    return up > 0 && down == 0;
  endfunction

  // Rank all points and queue the expected result stream
  task automatic rank_points();
    int unsigned nd, npts, k, fill, sc, pos;
    int unsigned best_i [K_MAX];
    int unsigned best_s [K_MAX];
    ranked_pt_t  r;
    nd = eff_dims();
    npts = (elem_cnt + nd - 1) / nd;
    if (npts > N_MAX) npts = N_MAX;
    k = (topk_reg == 0) ? 1 : (topk_reg > K_MAX ? K_MAX : topk_reg);
    if (npts == 0) begin
      r = '{0, 0, 1'b1, 1'b1, dropped};
      pending_ranks.push_back(r);
    end else begin
      fill = 0;
      for (int unsigned i = 0; i < npts; i++) begin
        sc = 0;
        for (int unsigned j = 0; j < npts; j++)
          if (j != i && beats(i, j, nd)) sc++;
        if (fill >= k && sc <= best_s[k-1]) continue;
        pos = (fill < k) ? fill : k - 1;
        while (pos > 0 && best_s[pos-1] < sc) begin
          best_s[pos] = best_s[pos-1];
          best_i[pos] = best_i[pos-1];
          pos--;
        end
        best_s[pos] = sc;
        best_i[pos] = i;
        if (fill < k) fill++;
      end
      for (int unsigned i = 0; i < fill; i++) begin
        r = '{best_i[i], best_s[i], i + 1 == fill, 1'b0, dropped};
        pending_ranks.push_back(r);
      end
    end
    elem_cnt = 0;
    dropped = 1'b0;
  endtask

  // Drive one input transfer; valid stays high on return for back-to-back sends
  task automatic send_item(input logic signed [31:0] v, input bit miss, input bit eos);
    int unsigned gap, cap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, miss, v};
    s_tuser <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (eos) begin
      rank_points();
    end else begin
      cap = N_MAX * eff_dims();
      if (cap > DEPTH) cap = DEPTH;
      if (elem_cnt < cap) begin
        elem_val[elem_cnt] = v;
        elem_miss[elem_cnt] = miss;
        elem_cnt++;
      end else begin
        dropped = 1'b1;
      end
    end
  endtask

  // Lower valid in the step of the last acceptance and wait out all results
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DIM: dims_reg = val & 8'h0F;
      CFG_DIR: dir_reg = val;
      CFG_TOP: topk_reg = val & 8'h1F;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  // Load a set of random points, optionally cut short, then end it
  task automatic send_random_set(input int unsigned npts);
    int unsigned nd, total;
    nd = eff_dims();
    total = npts * nd;
    if (total > 0 && $urandom_range(0, 3) == 0) total -= $urandom_range(1, nd);
    for (int unsigned e = 0; e < total; e++)
      send_item(pick_value(), $urandom_range(0, 3) == 0, 1'b0);
    send_item($urandom, $urandom_range(0, 1), 1'b1);
  endtask

  // Result checker and receiver stall generator
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    ranked_pt_t exp_r;
    logic       nxt_ready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_ranks.size() == 0) begin
          $display("%0t: unexpected result idx=%0d score=%0d", $time,
                   m_tdata[9:0], m_tdata[19:10]);
          mismatches++;
        end else begin
          exp_r = pending_ranks.pop_front();
          if (m_tdata[9:0] != exp_r.pidx[9:0] || m_tdata[19:10] != exp_r.pscore[9:0] ||
              m_tdata[20] != exp_r.povf || m_tlast != exp_r.plast ||
              m_tuser != exp_r.pempty) begin
            $display("%0t: expected idx=%0d score=%0d ovf=%0b last=%0b empty=%0b", $time,
                     exp_r.pidx, exp_r.pscore, exp_r.povf, exp_r.plast, exp_r.pempty);
            $display("%0t: actual   idx=%0d score=%0d ovf=%0b last=%0b empty=%0b", $time,
                     m_tdata[9:0], m_tdata[19:10], m_tdata[20], m_tlast, m_tuser);
            mismatches++;
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 7);
      end
      nxt_ready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
      m_tready <= nxt_ready;
    end
  end

  task automatic test_empty_set();
    send_item(32'sd5, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_extremes();
    write_reg(CFG_DIM, 8'd2);
    write_reg(CFG_DIR, 8'h01);
    write_reg(CFG_TOP, 8'd16);
    send_item(32'sh7FFFFFFF, 1'b0, 1'b0);
    send_item(32'sh80000000, 1'b0, 1'b0);
    send_item(32'sh80000000, 1'b0, 1'b0);
    send_item(32'sh7FFFFFFF, 1'b0, 1'b0);
    send_item(32'sh7FFFFFFF, 1'b0, 1'b0);
    send_item(32'sh7FFFFFFF, 1'b1, 1'b0);
    send_item(32'sd0, 1'b1, 1'b0);
    send_item(32'sd0, 1'b1, 1'b0);
    send_item(-32'sd1, 1'b0, 1'b0);
    send_item(-32'sd1, 1'b0, 1'b0);
    send_item(32'sd0, 1'b0, 1'b1);
    wait_drain();
  endtask

  // Partial last point, clamped dimension and top counts, count changed mid-set
  task automatic test_clamps_and_partial();
    write_reg(CFG_DIM, 8'd3);
    write_reg(CFG_DIR, 8'hFF);
    write_reg(CFG_TOP, 8'd0);
    send_random_set(3);
    send_item(32'sd1, 1'b0, 1'b0);
    send_item(32'sd2, 1'b0, 1'b1);
    wait_drain();
    write_reg(CFG_DIM, 8'd0);
    write_reg(CFG_TOP, 8'd31);
    send_random_set(6);
    wait_drain();
    write_reg(CFG_DIM, 8'hFC);
    write_reg(CFG_DIR, 8'h00);
    send_random_set(3);
    wait_drain();
    write_reg(CFG_DIM, 8'd2);
    for (int i = 0; i < 4; i++) send_item(pick_value(), 1'b0, 1'b0);
    wait_drain();
    write_reg(CFG_DIM, 8'd3);
    for (int i = 0; i < 3; i++) send_item(pick_value(), 1'b0, 1'b0);
    send_item(32'sd0, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_sets();
    while (items_sent < 430) begin
      wait_drain();
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) write_reg(CFG_DIM, $urandom_range(0, 255));
      if ($urandom_range(0, 1)) write_reg(CFG_DIR, $urandom_range(0, 255));
      if ($urandom_range(0, 1)) write_reg(CFG_TOP, $urandom_range(0, 255));
      send_random_set($urandom_range(0, 12));
    end
    wait_drain();
    calm = 1'b0;
  endtask

  // Fill past capacity so elements are dropped
  task automatic test_overflow();
    write_reg(CFG_DIM, 8'd1);
    write_reg(CFG_TOP, 8'd16);
    for (int i = 0; i < N_MAX + 3; i++)
      send_item($signed($urandom_range(0, 40)) - 20, $urandom_range(0, 7) == 0, 1'b0);
    send_item(32'sd0, 1'b0, 1'b1);
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_set();
    test_extremes();
    test_clamps_and_partial();
    test_random_sets();
    test_overflow();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("Verification failed");
    $finish;
  end
endmodule
